// ----- rtl/ics_pkg.sv -----
// Shared constants and types for the column projection block.
`timescale 1ns / 1ps
package ics_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 65535;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 16;
  localparam int WREG_W     = 13;
  localparam int SUM_W      = 24;
  localparam int PIX_W      = 8;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [WREG_W-1:0] WIDTH_RST  = WREG_W'(640);
  localparam logic [ROW_W-1:0]  HEIGHT_RST = ROW_W'(480);
  localparam logic [WREG_W-1:0] WIDTH_MAX  = WREG_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0]  HEIGHT_MAX = ROW_W'(MAX_HEIGHT);

  // effective geometry toward the datapath
  typedef struct packed {
    logic              mode;
    logic [WREG_W-1:0] width;
    logic [ROW_W-1:0]  height;
    logic              restart;
  } cfg_ctl_t;

  typedef struct packed {
    logic             last;
    logic [SUM_W-1:0] sum;
    logic [COL_W-1:0] column;
  } res_t;

endpackage

// ----- rtl/ics_cfg.sv -----
// Register file behind the configuration port, with clamped geometry.
`timescale 1ns / 1ps
module ics_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ics_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [ics_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [ics_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready,
  output ics_pkg::cfg_ctl_t             ctl
);

  logic                          mode_r;
  logic [ics_pkg::WREG_W-1:0]    width_r;
  logic [ics_pkg::ROW_W-1:0]     height_r;
  logic                          wr_en;
  logic [1:0]                    idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      width_r  <= ics_pkg::WIDTH_RST;
      height_r <= ics_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      unique case (idx)
        ics_pkg::REG_MODE:   mode_r   <= cfg_pwdata[0];
        ics_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[ics_pkg::WREG_W-1:0];
        ics_pkg::REG_HEIGHT: height_r <= cfg_pwdata[ics_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ics_pkg::REG_MODE:   cfg_prdata = {{(ics_pkg::DATA_W-1){1'b0}}, mode_r};
      ics_pkg::REG_WIDTH:  cfg_prdata = {{(ics_pkg::DATA_W-ics_pkg::WREG_W){1'b0}}, width_r};
      ics_pkg::REG_HEIGHT: cfg_prdata = {{(ics_pkg::DATA_W-ics_pkg::ROW_W){1'b0}}, height_r};
      default:             cfg_prdata = '0;
    endcase
  end

  always_comb begin
    ctl.mode = mode_r;
    if (width_r == '0)
      ctl.width = ics_pkg::WREG_W'(1);
    else if (width_r > ics_pkg::WIDTH_MAX)
      ctl.width = ics_pkg::WIDTH_MAX;
    else
      ctl.width = width_r;
    if (height_r == '0)
      ctl.height = ics_pkg::ROW_W'(1);
    else if (height_r > ics_pkg::HEIGHT_MAX)
      ctl.height = ics_pkg::HEIGHT_MAX;
    else
      ctl.height = height_r;
    // geometry writes restart the frame
    ctl.restart = wr_en & ((idx == ics_pkg::REG_WIDTH) | (idx == ics_pkg::REG_HEIGHT));
  end

endmodule

// ----- rtl/ics_acc_mem.sv -----
// Column accumulator store: one write port, one registered read port.
`timescale 1ns / 1ps
module ics_acc_mem (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [ics_pkg::COL_W-1:0]    rd_addr,
  output logic [ics_pkg::SUM_W-1:0]    rd_data,
  input  logic                         wr_en,
  input  logic [ics_pkg::COL_W-1:0]    wr_addr,
  input  logic [ics_pkg::SUM_W-1:0]    wr_data
);

  logic [ics_pkg::SUM_W-1:0] mem [ics_pkg::MAX_WIDTH];
  logic [ics_pkg::SUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[wr_addr] <= wr_data;
  end

  // read-before-write; the caller forwards same-cycle writes
  always_ff @(posedge clk) begin
    if (rd_en)
      rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/ics_res_fifo.sv -----
// Small result queue taking up to two results per cycle.
`timescale 1ns / 1ps
module ics_res_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_a,
  input  ics_pkg::res_t                 data_a,
  input  logic                          push_b,
  input  ics_pkg::res_t                 data_b,
  output logic [ics_pkg::FIFO_CW-1:0]   count,
  output logic                          out_valid,
  output ics_pkg::res_t                 out_data,
  input  logic                          out_ready
);

  ics_pkg::res_t                 q [ics_pkg::FIFO_DEPTH];
  logic [ics_pkg::FIFO_AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [ics_pkg::FIFO_CW-1:0]   cnt_r, cnt_nxt;
  logic                          pop;
  logic [ics_pkg::FIFO_CW-1:0]   n_push;
  ics_pkg::res_t                 first_d;

  assign pop       = out_valid & out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = q[rp_r];
  assign count     = cnt_r;
  assign n_push    = ics_pkg::FIFO_CW'(push_a) + ics_pkg::FIFO_CW'(push_b);
  assign first_d   = push_a ? data_a : data_b;

  always_comb begin
    wp_nxt  = wp_r + ics_pkg::FIFO_AW'(n_push);
    rp_nxt  = rp_r + ics_pkg::FIFO_AW'(pop);
    cnt_nxt = cnt_r + n_push - ics_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_a | push_b)
      q[wp_r] <= first_d;
    if (push_a & push_b)
      q[wp_r + ics_pkg::FIFO_AW'(1)] <= data_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/image_column_sum_projection.sv -----
// Top level of the column projection block: counters, accumulate pipeline, result queue.
`timescale 1ns / 1ps
// Usage:
//  - in_* : 8-bit pixels in raster order, one transfer per pixel.
//  - out_*: column results; tdata = {column_sum, column}, tlast marks the final
//    column of the frame. Results come only during the last row of a frame.
//  - cfg_*: APB registers mode (0x0), row_width (0x4), frame_height (0x8).
//    Writing row_width or frame_height restarts the frame. Write only while idle.
// Timing: one pixel per cycle sustained while in_tready is high. A pixel
//  read-modify-writes its column accumulator (memory read, then add and write
//  back); a pixel hitting the same column as the one before is served by forwarding.
//  A result passes through stage 1 and then the result queue before it reaches out_*.
// Stall: a four-entry result queue sits before out_*. in_tready drops only when
//  the queue cannot take the results still in flight plus two more; the
//  gradient-mode final pixel can emit two results.
// Reset: counters, previous pixel and registers return to defaults
//  (mode 0, 640 x 480). The accumulator store is not cleared: the first row
//  of each frame overwrites it, so no clearing pass is needed.
module image_column_sum_projection (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,    // [7:0] pixel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata,   // [11:0] column, [35:12] column_sum
  output logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ics_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [ics_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [ics_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int CW = ics_pkg::COL_W;
  localparam int RW = ics_pkg::ROW_W;
  localparam int SW = ics_pkg::SUM_W;
  localparam int PW = ics_pkg::PIX_W;

  ics_pkg::cfg_ctl_t ctl;

  ics_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .ctl         (ctl)
  );

  // frame position
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [PW-1:0] prev_r;

  // stage 1: memory data back, add and write
  logic          s1_valid_r;
  logic          s1_wr_r;
  logic [CW-1:0] s1_addr_r;
  logic [PW-1:0] s1_val_r;
  logic          s1_first_r;
  logic          s1_emit_a_r;
  logic          s1_a_last_r;
  logic          s1_emit_b_r;
  logic [CW-1:0] s1_colb_r;
  logic          fwd_sel_r;
  logic [SW-1:0] fwd_data_r;

  logic          accept;
  logic [PW-1:0] pix;
  logic          first_row, last_row, last_col;
  logic [PW-1:0] diff;
  logic          wr0;
  logic [CW-1:0] addr0;
  logic [PW-1:0] val0;
  logic          fwd_hit;
  logic [SW-1:0] mem_rd;
  logic [SW-1:0] base;
  logic [SW-1:0] s1_sum;
  logic          s1_write;
  logic [ics_pkg::FIFO_CW-1:0] q_count;
  logic [ics_pkg::FIFO_CW-1:0] n_flight;
  ics_pkg::res_t res_a, res_b, res_out;

  assign pix    = in_tdata[PW-1:0];
  assign accept = in_tvalid & in_tready;

  assign first_row = (row_r == '0);
  assign last_row  = (({1'b0, row_r} + (RW+1)'(1)) >= {1'b0, ctl.height});
  assign last_col  = (({1'b0, col_r} + ics_pkg::WREG_W'(1)) >= ctl.width);
  assign diff      = (pix > prev_r) ? (pix - prev_r) : (prev_r - pix);

  // gradient mode: column c completes column c-1; column 0 only primes prev
  assign wr0   = ~ctl.mode | (col_r != '0);
  assign addr0 = ctl.mode ? (col_r - CW'(1)) : col_r;
  assign val0  = ctl.mode ? diff : pix;

  assign s1_write = s1_valid_r & s1_wr_r;
  assign fwd_hit  = s1_write & (s1_addr_r == addr0);

  // room for what is in stage 1 plus the worst case of two new results
  assign n_flight  = s1_valid_r ?
                     (ics_pkg::FIFO_CW'(s1_emit_a_r) + ics_pkg::FIFO_CW'(s1_emit_b_r)) : '0;
  assign in_tready = ((q_count + n_flight) <= ics_pkg::FIFO_CW'(ics_pkg::FIFO_DEPTH - 2));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (ctl.restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : (row_r + RW'(1));
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      prev_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= accept;
      if (accept)
        prev_r <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wr_r     <= wr0;
      s1_addr_r   <= addr0;
      s1_val_r    <= val0;
      s1_first_r  <= first_row;
      s1_emit_a_r <= wr0 & last_row;
      s1_a_last_r <= ~ctl.mode & last_col;
      s1_emit_b_r <= ctl.mode & last_row & last_col;
      s1_colb_r   <= col_r;
      fwd_sel_r   <= fwd_hit;
      fwd_data_r  <= s1_sum;
    end
  end

  ics_acc_mem u_mem (
    .clk     (clk),
    .rd_en   (accept & wr0),
    .rd_addr (addr0),
    .rd_data (mem_rd),
    .wr_en   (s1_write),
    .wr_addr (s1_addr_r),
    .wr_data (s1_sum)
  );

  assign base   = fwd_sel_r ? fwd_data_r : mem_rd;
  assign s1_sum = s1_first_r ? SW'(s1_val_r) : (base + SW'(s1_val_r));

  always_comb begin
    res_a.column = s1_addr_r;
    res_a.sum    = s1_sum;
    res_a.last   = s1_a_last_r;
    res_b.column = s1_colb_r;
    res_b.sum    = '0;
    res_b.last   = 1'b1;
  end

  ics_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (s1_valid_r & s1_emit_a_r),
    .data_a    (res_a),
    .push_b    (s1_valid_r & s1_emit_b_r),
    .data_b    (res_b),
    .count     (q_count),
    .out_valid (out_tvalid),
    .out_data  (res_out),
    .out_ready (out_tready)
  );

  assign out_tdata = {4'b0, res_out.sum, res_out.column};
  assign out_tlast = res_out.last;

endmodule

// ----- dv/tb_image_column_sum_projection.sv -----
// Self-checking testbench for the column projection block: directed table, then random frames.
`timescale 1ns / 1ps
module tb_image_column_sum_projection;

  // Register index with no register behind it; writes to it must be ignored.
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic       MODE_PLAIN = 1'b0;
  localparam logic       MODE_GRAD  = 1'b1;
  localparam int         SETTLE     = 8;      // results trail their pixel through stage 1 and the result queue
  localparam int         RAND_ITEMS = 1700;
  localparam int         QUIET_FROM = 1400;   // random pixels after which idling stops
  localparam int         EXT_ITEMS  = 64;     // pixels sent into each oversized frame
  localparam int         NO_LIMIT   = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_TYPED} row_kind_t;

  // Pixel patterns for one frame.
  typedef enum logic [1:0] {PIX_RANDOM, PIX_RAILS, PIX_FULL, PIX_LOW} pix_style_t;

  // One row of the directed table: a register write, or a pixel whose results
  // come from the column predictor or are typed in right here.
  typedef struct {
    row_kind_t     kind;
    logic [1:0]    idx;
    logic [31:0]   val;
    int            n;
    ics_pkg::res_t r0;
    ics_pkg::res_t r1;
  } dir_row_t;

  logic                         clk;
  logic                         rst_n       = 1'b0;
  logic                         in_tvalid   = 1'b0;
  logic                         in_tready;
  logic [7:0]                   in_tdata    = '0;   // [7:0] pixel
  logic                         out_tvalid;
  logic                         out_tready  = 1'b0;
  logic [39:0]                  out_tdata;          // [11:0] column, [35:12] column_sum
  logic                         out_tlast;
  logic                         cfg_psel    = 1'b0;
  logic                         cfg_penable = 1'b0;
  logic                         cfg_pwrite  = 1'b0;
  logic [ics_pkg::ADDR_W-1:0]   cfg_paddr   = '0;
  logic [ics_pkg::DATA_W-1:0]   cfg_pwdata  = '0;
  logic [ics_pkg::DATA_W-1:0]   cfg_prdata;
  logic                         cfg_pready;

  image_column_sum_projection DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Column predictor: registers, counters and the accumulator store as the
  // block should hold them.
  // ---------------------------------------------------------------------------
  logic                       cf_mode   = 1'b0;
  logic [ics_pkg::WREG_W-1:0] cf_width  = ics_pkg::WIDTH_RST;
  logic [ics_pkg::ROW_W-1:0]  cf_height = ics_pkg::HEIGHT_RST;
  bit   [ics_pkg::SUM_W-1:0]  col_acc [ics_pkg::MAX_WIDTH];
  int                         col_cnt  = 0;
  int                         row_cnt  = 0;
  logic [7:0]                 prev_pix = '0;

  ics_pkg::res_t col_sums_due [$];   // column sums still owed by the block, oldest first

  int  n_errors = 0;
  int  n_pix    = 0;
  int  n_res    = 0;
  int  n_frames = 0;
  int  n_writes = 0;
  int  n_cuts   = 0;
  int  n_flips  = 0;
  bit  in_gaps_on    = 1'b1;
  bit  out_stalls_on = 1'b1;
  int  stall_left    = 0;

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("timeout: results still owed %0d", col_sums_due.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic int eff_w();
    if (cf_width == 0) return 1;
    if (cf_width > ics_pkg::WIDTH_MAX) return ics_pkg::MAX_WIDTH;
    return int'(cf_width);
  endfunction

  function automatic int eff_h();
    if (cf_height == 0) return 1;
    return int'(cf_height);   // 16 bits cannot exceed MAX_HEIGHT
  endfunction

  function automatic ics_pkg::res_t mkres(input int col,
                                          input logic [ics_pkg::SUM_W-1:0] sum,
                                          input logic last);
    ics_pkg::res_t x;
    x.column = col[ics_pkg::COL_W-1:0];
    x.sum    = sum;
    x.last   = last;
    return x;
  endfunction

  function automatic logic [ics_pkg::DATA_W-1:0] reg_value(input logic [1:0] idx);
    case (idx)
      ics_pkg::REG_MODE:  return ics_pkg::DATA_W'(cf_mode);
      ics_pkg::REG_WIDTH: return ics_pkg::DATA_W'(cf_width);
      default:            return ics_pkg::DATA_W'(cf_height);
    endcase
  endfunction

  // Geometry writes restart the frame; a mode write only changes what the
  // next pixel does.
  function automatic void set_reg(input logic [1:0] idx, input logic [31:0] v);
    case (idx)
      ics_pkg::REG_MODE: cf_mode = v[0];
      ics_pkg::REG_WIDTH: begin
        cf_width = v[ics_pkg::WREG_W-1:0];
        col_cnt  = 0;
        row_cnt  = 0;
      end
      ics_pkg::REG_HEIGHT: begin
        cf_height = v[ics_pkg::ROW_W-1:0];
        col_cnt   = 0;
        row_cnt   = 0;
      end
      default: ;
    endcase
  endfunction

  // One pixel through the column store. Returns how many sums it finishes.
  function automatic int column_step(input logic [7:0] p, output ics_pkg::res_t r0,
                                     output ics_pkg::res_t r1);
    int                        w, h, c, r, n;
    bit                        first_row, last_row, last_col;
    logic [7:0]                d;
    logic [ics_pkg::SUM_W-1:0] s;
    w = eff_w();
    h = eff_h();
    c = col_cnt;
    r = row_cnt;
    n = 0;
    r0 = '0;
    r1 = '0;
    first_row = (r == 0);
    last_row  = (r + 1 >= h);
    last_col  = (c + 1 >= w);
    if (cf_mode == MODE_PLAIN) begin
      s = first_row ? ics_pkg::SUM_W'(p) : col_acc[c] + ics_pkg::SUM_W'(p);
      col_acc[c] = s;
      if (last_row) begin
        r0 = mkres(c, s, last_col);
        n  = 1;
      end
    end else begin
      // pixel at column c closes the difference for column c-1
      if (c >= 1) begin
        d = (p > prev_pix) ? p - prev_pix : prev_pix - p;
        s = first_row ? ics_pkg::SUM_W'(d) : col_acc[c-1] + ics_pkg::SUM_W'(d);
        col_acc[c-1] = s;
        if (last_row) begin
          r0 = mkres(c - 1, s, 1'b0);
          n  = 1;
        end
      end
      // rightmost column has no neighbour: reported as zero, closes the frame
      if (last_row && last_col) begin
        if (n == 0) r0 = mkres(c, '0, 1'b1);
        else        r1 = mkres(c, '0, 1'b1);
        n++;
      end
    end
    prev_pix = p;
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts on out_tready, and every transfer is
  // checked against the oldest sum still owed.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    n_errors++;
    $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  task automatic check_col_sum();
    ics_pkg::res_t want;
    if (col_sums_due.size() == 0) begin
      report_mismatch("unexpected result", out_tdata, 0);
    end else begin
      want = col_sums_due.pop_front();
      n_res++;
      if (out_tdata[11:0] !== want.column)
        report_mismatch("column", out_tdata[11:0], want.column);
      if (out_tdata[35:12] !== want.sum)
        report_mismatch($sformatf("column_sum of column %0d", want.column),
                        out_tdata[35:12], want.sum);
      if (out_tlast !== want.last)
        report_mismatch($sformatf("last of column %0d", want.column), out_tlast, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      check_col_sum();
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (out_stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);   // start a burst; stall_left counts what is left of it
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Register port. Each access ends by dropping psel and waiting for a clock edge, so psel
  // never gets two updates in one step.
  // ---------------------------------------------------------------------------
  task automatic apb_read_check(input logic [1:0] idx);
    logic [ics_pkg::DATA_W-1:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (got !== reg_value(idx))
      report_mismatch($sformatf("read of register %0d", idx), got, reg_value(idx));
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    set_reg(idx, v);
    n_writes++;
    if (idx != REG_SPARE) apb_read_check(idx);
  endtask

  // ---------------------------------------------------------------------------
  // Pixel side
  // ---------------------------------------------------------------------------

  // Hold valid low until every owed sum is out, then give the pipeline time
  // to finish pixels that owe nothing.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (col_sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Returns in the step of the transfer with valid still high; the caller's
  // next action either drives a new pixel or lowers valid.
  task automatic send_pixel(input logic [7:0] p);
    if (in_gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_pix++;
  endtask

  task automatic send_predicted(input logic [7:0] p);
    ics_pkg::res_t a, b;
    int            n;
    send_pixel(p);
    n = column_step(p, a, b);
    if (n > 0) col_sums_due.push_back(a);
    if (n > 1) col_sums_due.push_back(b);
  endtask

  task automatic send_typed(input dir_row_t row);
    ics_pkg::res_t a, b;
    send_pixel(row.val[7:0]);
    void'(column_step(row.val[7:0], a, b));   // keep predictor state in step
    if (row.n > 0) col_sums_due.push_back(row.r0);
    if (row.n > 1) col_sums_due.push_back(row.r1);
  endtask

  // One frame at the current geometry, at most limit pixels long. With twists
  // enabled it may flip to gradient mode after the first row, pause until
  // idle, or be cut short early. A cut rewrites the height, which restarts
  // the frame.
  task automatic run_frame(input pix_style_t style, input bit twists, input int limit);
    int         total, flip_at, pause_at, cut_at;
    logic [7:0] p;
    total    = eff_w() * eff_h();
    flip_at  = -1;
    pause_at = -1;
    cut_at   = -1;
    if (twists) begin
      if (cf_mode == MODE_PLAIN && eff_h() >= 2 && $urandom_range(0, 3) == 0)
        flip_at = $urandom_range(eff_w(), total - 1);
      if ($urandom_range(0, 7) == 0)
        pause_at = $urandom_range(0, total - 1);
      if (total > 1 && $urandom_range(0, 11) == 0)
        cut_at = $urandom_range(1, total - 1);
    end
    for (int k = 0; k < total; k++) begin
      if (k == cut_at || k == limit) begin
        drain();
        apb_write(ics_pkg::REG_HEIGHT, ics_pkg::DATA_W'(cf_height));
        n_cuts++;
        return;
      end
      // plain to gradient after row 0: every column it reads was written
      if (k == flip_at) begin
        drain();
        apb_write(ics_pkg::REG_MODE, ics_pkg::DATA_W'(MODE_GRAD));
        n_flips++;
      end
      if (k == pause_at) drain();
      case (style)
        PIX_RAILS: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        PIX_FULL:  p = 8'hFF;
        PIX_LOW:   p = 8'($urandom_range(0, 3));
        default:   p = 8'($urandom());
      endcase
      send_predicted(p);
    end
    n_frames++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [$];

  function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] v);
    dir_row_t row;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.val  = v;
    row.n    = 0;
    row.r0   = '0;
    row.r1   = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_pix(input logic [7:0] p, input row_kind_t kind, input int n,
                                  input ics_pkg::res_t r0, input ics_pkg::res_t r1);
    dir_row_t row;
    row.kind = kind;
    row.idx  = '0;
    row.val  = 32'(p);
    row.n    = n;
    row.r0   = r0;
    row.r1   = r1;
    dir_rows.push_back(row);
  endfunction

  function automatic void build_dir_rows();
    // plain 3x2: sums land on the second row
    add_cfg(ics_pkg::REG_WIDTH, 32'd3);
    add_cfg(ics_pkg::REG_HEIGHT, 32'd2);
    add_pix(8'd0,   ROW_PIX_TYPED, 0, '0, '0);
    add_pix(8'd255, ROW_PIX_TYPED, 0, '0, '0);
    add_pix(8'd17,  ROW_PIX_TYPED, 0, '0, '0);
    add_pix(8'd255, ROW_PIX_TYPED, 1, mkres(0, 24'd255, 1'b0), '0);
    add_pix(8'd0,   ROW_PIX_TYPED, 1, mkres(1, 24'd255, 1'b0), '0);
    add_pix(8'd200, ROW_PIX_TYPED, 1, mkres(2, 24'd217, 1'b1), '0);
    // gradient 3x2: final pixel closes column 1 and emits the zero column 2
    add_cfg(ics_pkg::REG_MODE, ics_pkg::DATA_W'(MODE_GRAD));
    add_pix(8'd10,  ROW_PIX_TYPED, 0, '0, '0);
    add_pix(8'd250, ROW_PIX_TYPED, 0, '0, '0);
    add_pix(8'd0,   ROW_PIX_TYPED, 0, '0, '0);
    add_pix(8'd255, ROW_PIX_TYPED, 0, '0, '0);
    add_pix(8'd0,   ROW_PIX_TYPED, 1, mkres(0, 24'd495, 1'b0), '0);
    add_pix(8'd128, ROW_PIX_TYPED, 2, mkres(1, 24'd378, 1'b0), mkres(2, 24'd0, 1'b1));
    // single pixel frame in gradient mode: only the zero column
    add_cfg(ics_pkg::REG_WIDTH, 32'd1);
    add_cfg(ics_pkg::REG_HEIGHT, 32'd1);
    add_pix(8'hAA, ROW_PIX_TYPED, 1, mkres(0, 24'd0, 1'b1), '0);
    // zero width and height behave as one
    add_cfg(ics_pkg::REG_MODE, ics_pkg::DATA_W'(MODE_PLAIN));
    add_cfg(ics_pkg::REG_WIDTH, 32'd0);
    add_cfg(ics_pkg::REG_HEIGHT, 32'd0);
    add_pix(8'h55, ROW_PIX_TYPED, 1, mkres(0, 24'h55, 1'b1), '0);
    add_pix(8'hFF, ROW_PIX_TYPED, 1, mkres(0, 24'hFF, 1'b1), '0);
    // write to the unused index changes nothing
    add_cfg(REG_SPARE, 32'hFFFF_FFFF);
    add_pix(8'h01, ROW_PIX_TYPED, 1, mkres(0, 24'h01, 1'b1), '0);
    // gradient 2x1
    add_cfg(ics_pkg::REG_MODE, ics_pkg::DATA_W'(MODE_GRAD));
    add_cfg(ics_pkg::REG_WIDTH, 32'd2);
    add_cfg(ics_pkg::REG_HEIGHT, 32'd1);
    add_pix(8'd7,   ROW_PIX_TYPED, 0, '0, '0);
    add_pix(8'd200, ROW_PIX_TYPED, 2, mkres(0, 24'd193, 1'b0), mkres(1, 24'd0, 1'b1));
    // plain 4x1 through the predictor
    add_cfg(ics_pkg::REG_MODE, ics_pkg::DATA_W'(MODE_PLAIN));
    add_cfg(ics_pkg::REG_WIDTH, 32'd4);
    add_pix(8'h80, ROW_PIX, 0, '0, '0);
    add_pix(8'h7F, ROW_PIX, 0, '0, '0);
    add_pix(8'hC3, ROW_PIX, 0, '0, '0);
    add_pix(8'h3C, ROW_PIX, 0, '0, '0);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_width();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0)  return 32'd0;
    if (r <= 15) return 32'($urandom_range(1, 16));
    if (r <= 18) return 32'($urandom_range(17, 100));
    return 32'($urandom_range(101, 300));
  endfunction

  function automatic logic [31:0] pick_height();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0)  return 32'd0;
    if (r <= 13) return 32'($urandom_range(1, 4));
    return 32'($urandom_range(5, 12));
  endfunction

  initial begin
    int         rand_start, n_frames_here;
    pix_style_t style;
    build_dir_rows();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers must come out of reset at 0 / 640 / 480
    apb_read_check(ics_pkg::REG_MODE);
    apb_read_check(ics_pkg::REG_WIDTH);
    apb_read_check(ics_pkg::REG_HEIGHT);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          drain();
          apb_write(dir_rows[i].idx, dir_rows[i].val);
        end
        ROW_PIX:  send_predicted(dir_rows[i].val[7:0]);
        default:  send_typed(dir_rows[i]);
      endcase
    end

    // Geometry extremes, each cut short after a few dozen pixels: the widest
    // row in both modes (the second through an over-range width that clamps),
    // and the tallest frame of one column.
    drain();
    apb_write(ics_pkg::REG_WIDTH, 32'd4096);
    apb_write(ics_pkg::REG_HEIGHT, 32'd1);
    run_frame(PIX_RANDOM, 1'b0, EXT_ITEMS);
    drain();
    apb_write(ics_pkg::REG_MODE, ics_pkg::DATA_W'(MODE_GRAD));
    apb_write(ics_pkg::REG_WIDTH, 32'h1FFF);
    run_frame(PIX_RAILS, 1'b0, EXT_ITEMS);
    drain();
    apb_write(ics_pkg::REG_MODE, ics_pkg::DATA_W'(MODE_PLAIN));
    apb_write(ics_pkg::REG_WIDTH, 32'd1);
    apb_write(ics_pkg::REG_HEIGHT, 32'hFFFF);
    run_frame(PIX_FULL, 1'b0, EXT_ITEMS);

    // Random phases of one to three frames each: a new mode, and at random new geometry, per phase.
    rand_start = n_pix;
    while (n_pix - rand_start < RAND_ITEMS) begin
      drain();
      if (n_pix - rand_start >= QUIET_FROM) begin
        in_gaps_on    <= 1'b0;
        out_stalls_on <= 1'b0;
      end else begin
        in_gaps_on    <= ($urandom_range(0, 3) != 0);
        out_stalls_on <= ($urandom_range(0, 3) != 0);
      end
      apb_write(ics_pkg::REG_MODE, ics_pkg::DATA_W'($urandom_range(0, 1)));
      if (n_pix - rand_start == 0 || $urandom_range(0, 1) == 0) begin
        apb_write(ics_pkg::REG_WIDTH, pick_width());
        apb_write(ics_pkg::REG_HEIGHT, pick_height());
      end
      n_frames_here = $urandom_range(1, 3);
      repeat (n_frames_here) begin
        case ($urandom_range(0, 9))
          0:       style = PIX_RAILS;
          1:       style = PIX_LOW;
          2:       style = PIX_FULL;
          default: style = PIX_RANDOM;
        endcase
        if (n_pix - rand_start < RAND_ITEMS)
          run_frame(style, 1'b1, RAND_ITEMS - (n_pix - rand_start));
      end
    end

    drain();
    $display("covered %0d pixels, %0d column results, %0d whole frames, %0d register writes",
             n_pix, n_res, n_frames, n_writes);
    $display("both modes, rows up to 4096 wide and frames up to 65535 tall (cut short), %0d %s",
             n_cuts, $sformatf("restarts, %0d mode flips", n_flips));
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
